// ===== sv/spprb_pkg.sv =====
package spprb_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 16;
    localparam int SADDR_W    = 7;
    localparam int WORD_W     = 32;
    localparam int PADDR_W    = 3;

    localparam logic [SADDR_W-1:0] SENSOR_ADDRESS_RESET = 7'd90;
    localparam logic [IDX_W-1:0]   RING_TOP_RESET       = 10'd709;

    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] CMD_OBJECT  = 8'h07;
    localparam logic [7:0] CMD_AMBIENT = 8'h06;

    // Byte addresses of the configuration registers.
    localparam logic [PADDR_W-1:0] REG_SENSOR_ADDRESS = 3'h0;
    localparam logic [PADDR_W-1:0] REG_RING_TOP       = 3'h4;

    typedef enum logic [1:0] {
        PH_DISABLE,
        PH_TARGET,
        PH_READ,
        PH_CHECK
    } t_phase;

    typedef enum logic [2:0] {
        BUS_DISABLE   = 3'd0,
        BUS_TARGET    = 3'd1,
        BUS_READ      = 3'd2,
        BUS_CLEAR_INT = 3'd3,
        BUS_ABORT     = 3'd4,
        BUS_NONE      = 3'd5
    } t_bus_op;

    typedef struct packed {
        logic object_ok;
        logic ambient_ok;
    } t_pec_status;

    // One byte through the CRC-8 register, MSB first.
    function automatic logic [7:0] crc_byte(input logic [7:0] v);
        logic [7:0] c;
        c = v;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // CRC over write address, command and read address of an SMBus read word.
    function automatic logic [7:0] pec_seed(input logic [SADDR_W-1:0] addr,
                                            input logic [7:0] cmd);
        logic [7:0] a;
        logic [7:0] s;
        a = {addr, 1'b0};
        s = crc_byte(a);
        s = crc_byte(s ^ cmd);
        return crc_byte(s ^ {addr, 1'b1});
    endfunction

endpackage

// ===== sv/spprb_if.sv =====
interface spprb_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic       abort_seen;
    logic [7:0] object_low;
    logic [7:0] object_high;
    logic [7:0] object_pec;
    logic [7:0] ambient_low;
    logic [7:0] ambient_high;
    logic [7:0] ambient_pec;

    modport source (
        output valid, action, abort_seen, object_low, object_high, object_pec,
               ambient_low, ambient_high, ambient_pec,
        input  ready
    );
    modport sink (
        input  valid, action, abort_seen, object_low, object_high, object_pec,
               ambient_low, ambient_high, ambient_pec,
        output ready
    );
endinterface

interface spprb_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         bus_op;
    logic               sample_valid;
    logic signed [15:0] object_temp;
    logic signed [15:0] ambient_temp;
    logic [15:0]        sequence_res;
    logic [9:0]         available;
    logic [15:0]        error_count;
    logic [15:0]        overrun_count;

    modport source (
        output valid, bus_op, sample_valid, object_temp, ambient_temp, sequence_res,
               available, error_count, overrun_count,
        input  ready
    );
    modport sink (
        input  valid, bus_op, sample_valid, object_temp, ambient_temp, sequence_res,
               available, error_count, overrun_count,
        output ready
    );
endinterface

// ===== sv/spprb_ram.sv =====
module spprb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/spprb_pec.sv =====
module spprb_pec import spprb_pkg::*; (
    input  logic [7:0]  i_seed_object,
    input  logic [7:0]  i_seed_ambient,
    input  logic [7:0]  i_object_low,
    input  logic [7:0]  i_object_high,
    input  logic [7:0]  i_object_pec,
    input  logic [7:0]  i_ambient_low,
    input  logic [7:0]  i_ambient_high,
    input  logic [7:0]  i_ambient_pec,
    output t_pec_status o_status
);

    logic [7:0] object_crc;
    logic [7:0] ambient_crc;

    // The seed already covers the address and command bytes, so only the
    // two data bytes remain.
    assign object_crc  = crc_byte(i_object_high ^ crc_byte(i_object_low ^ i_seed_object));
    assign ambient_crc = crc_byte(i_ambient_high ^ crc_byte(i_ambient_low ^ i_seed_ambient));

    assign o_status.object_ok  = (object_crc == i_object_pec);
    assign o_status.ambient_ok = (ambient_crc == i_ambient_pec);

endmodule

// ===== sv/sensor_poll_pec_ring_buffer_top.sv =====
// Poll sequencer and sample ring for a two-register SMBus temperature sensor.
// Each input beat is either a timer tick carrying the latest bus results or a
// pop request, and produces exactly one result beat in the cycle after it is
// accepted. A beat is accepted in every cycle while the single result
// register is empty or being drained, so the block sustains one beat per
// clock; when the sink stalls, input stalls with it. A pop reads the ring
// memory through its registered read port, which is what places the result
// in the cycle after acceptance. Packet error codes are checked against seeds
// that are recomputed whenever the sensor address register is written. The
// ring memory is not cleared at reset and needs no initialization time; only
// entries that were written are ever popped, as long as the ring top is not raised.
module sensor_poll_pec_ring_buffer_top import spprb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    spprb_in_if.sink           i_req,
    spprb_out_if.source        o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration
    logic [SADDR_W-1:0] r_sensor_address;
    logic [IDX_W-1:0]   r_ring_top;
    logic [7:0]         r_seed_object;
    logic [7:0]         r_seed_ambient;
    logic               cfg_we;

    // Ring and sequencer state
    t_phase             r_phase, n_phase;
    logic [IDX_W-1:0]   r_write_index, n_write_index;
    logic [IDX_W-1:0]   r_read_index, n_read_index;
    logic [CNT_W-1:0]   r_taken_count, n_taken_count;
    logic [CNT_W-1:0]   r_dropped_count, n_dropped_count;
    logic [CNT_W-1:0]   r_fault_count, n_fault_count;

    // Result register
    logic               r_out_valid;
    t_bus_op            r_bus_op;
    logic               r_sample_valid;
    logic [CNT_W-1:0]   r_sequence;
    logic [IDX_W-1:0]   r_available;
    logic [CNT_W-1:0]   r_error_count;
    logic [CNT_W-1:0]   r_overrun_count;

    logic               in_acc;
    t_pec_status        pec_status;
    logic               pec_good;
    t_bus_op            bus_op;
    logic               fault_inc;
    logic               store_pair;
    logic               pop_hit;
    logic [IDX_W-1:0]   avail_now;
    logic [IDX_W-1:0]   avail_next;
    logic [IDX_W-1:0]   adv_write;
    logic [WORD_W-1:0]  ram_rdata;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [IDX_W-1:0] top);
        return (idx >= top) ? '0 : idx + IDX_W'(1);
    endfunction

    // Samples waiting; a length still negative after wrapping (an index left above a lowered top) counts as empty.
    function automatic logic [IDX_W-1:0] waiting(input logic [IDX_W-1:0] w,
                                                 input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] top);
        logic signed [IDX_W+1:0] len;
        len = $signed({2'b00, w}) - $signed({2'b00, r});
        if (len < 0) begin
            len = len + $signed({2'b00, top}) + $signed((IDX_W+2)'(1));
        end
        if (len < 0) begin
            len = '0;
        end
        return len[IDX_W-1:0];
    endfunction

    // ---------------- Configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_address <= SENSOR_ADDRESS_RESET;
            r_ring_top       <= RING_TOP_RESET;
            r_seed_object    <= pec_seed(SENSOR_ADDRESS_RESET, CMD_OBJECT);
            r_seed_ambient   <= pec_seed(SENSOR_ADDRESS_RESET, CMD_AMBIENT);
        end else if (cfg_we) begin
            if (paddr == REG_SENSOR_ADDRESS) begin
                r_sensor_address <= pwdata[SADDR_W-1:0];
                r_seed_object    <= pec_seed(pwdata[SADDR_W-1:0], CMD_OBJECT);
                r_seed_ambient   <= pec_seed(pwdata[SADDR_W-1:0], CMD_AMBIENT);
            end else if (paddr == REG_RING_TOP) begin
                r_ring_top <= pwdata[IDX_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr)
            REG_SENSOR_ADDRESS: prdata = {{(32-SADDR_W){1'b0}}, r_sensor_address};
            REG_RING_TOP:       prdata = {{(32-IDX_W){1'b0}}, r_ring_top};
            default:            prdata = '0;
        endcase
    end

    // ---------------- Handshake ----------------
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign in_acc      = i_req.valid && i_req.ready;

    // ---------------- PEC check ----------------
    spprb_pec u_pec (
        .i_seed_object  (r_seed_object),
        .i_seed_ambient (r_seed_ambient),
        .i_object_low   (i_req.object_low),
        .i_object_high  (i_req.object_high),
        .i_object_pec   (i_req.object_pec),
        .i_ambient_low  (i_req.ambient_low),
        .i_ambient_high (i_req.ambient_high),
        .i_ambient_pec  (i_req.ambient_pec),
        .o_status       (pec_status)
    );

    assign pec_good = pec_status.object_ok && pec_status.ambient_ok;

    // ---------------- Sequencer: next phase ----------------
    always_comb begin
        n_phase = r_phase;
        if (in_acc && !i_req.action) begin
            unique case (r_phase)
                PH_DISABLE: n_phase = PH_TARGET;
                PH_TARGET:  n_phase = PH_READ;
                PH_READ:    n_phase = PH_CHECK;
                PH_CHECK:   n_phase = (i_req.abort_seen || !pec_good) ? PH_DISABLE : PH_CHECK;
                default:    n_phase = PH_DISABLE;
            endcase
        end
    end

    // ---------------- Sequencer: outputs ----------------
    always_comb begin
        bus_op     = BUS_NONE;
        fault_inc  = 1'b0;
        store_pair = 1'b0;
        if (!i_req.action) begin
            unique case (r_phase)
                PH_DISABLE: bus_op = BUS_DISABLE;
                PH_TARGET:  bus_op = BUS_TARGET;
                PH_READ:    bus_op = BUS_READ;
                PH_CHECK: begin
                    if (i_req.abort_seen) begin
                        bus_op    = BUS_CLEAR_INT;
                        fault_inc = 1'b1;
                    end else if (!pec_good) begin
                        bus_op    = BUS_ABORT;
                        fault_inc = 1'b1;
                    end else begin
                        bus_op     = BUS_READ;
                        store_pair = 1'b1;
                    end
                end
                default:    bus_op = BUS_DISABLE;
            endcase
        end
    end

    // ---------------- Ring bookkeeping ----------------
    assign avail_now = waiting(r_write_index, r_read_index, r_ring_top);
    assign pop_hit   = i_req.action && (avail_now != '0);
    assign adv_write = advance(r_write_index, r_ring_top);

    always_comb begin
        n_write_index   = r_write_index;
        n_read_index    = r_read_index;
        n_taken_count   = r_taken_count;
        n_dropped_count = r_dropped_count;
        n_fault_count   = r_fault_count;
        if (in_acc) begin
            if (fault_inc) begin
                n_fault_count = r_fault_count + CNT_W'(1);
            end
            if (store_pair) begin
                n_write_index = adv_write;
                // Full ring: the oldest sample is overwritten next, so drop it.
                if (adv_write == r_read_index) begin
                    n_read_index    = advance(r_read_index, r_ring_top);
                    n_dropped_count = r_dropped_count + CNT_W'(1);
                end
            end
            if (pop_hit) begin
                n_read_index  = advance(r_read_index, r_ring_top);
                n_taken_count = r_taken_count + CNT_W'(1);
            end
        end
    end

    assign avail_next = waiting(n_write_index, n_read_index, r_ring_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_DISABLE;
            r_write_index   <= '0;
            r_read_index    <= '0;
            r_taken_count   <= '0;
            r_dropped_count <= '0;
            r_fault_count   <= '0;
        end else begin
            r_phase         <= n_phase;
            r_write_index   <= n_write_index;
            r_read_index    <= n_read_index;
            r_taken_count   <= n_taken_count;
            r_dropped_count <= n_dropped_count;
            r_fault_count   <= n_fault_count;
        end
    end

    // ---------------- Sample memory ----------------
    spprb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc && store_pair),
        .i_waddr (r_write_index[RING_AW-1:0]),
        .i_wdata ({i_req.ambient_high, i_req.ambient_low,
                   i_req.object_high, i_req.object_low}),
        .i_re    (in_acc && pop_hit),
        .i_raddr (r_read_index[RING_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------- Result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_bus_op        <= bus_op;
            r_sample_valid  <= pop_hit;
            r_sequence      <= r_taken_count + r_dropped_count;
            r_available     <= avail_next;
            r_error_count   <= n_fault_count;
            r_overrun_count <= n_dropped_count;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.bus_op        = r_bus_op;
    assign o_rsp.sample_valid  = r_sample_valid;
    assign o_rsp.object_temp   = r_sample_valid ? $signed(ram_rdata[15:0]) : '0;
    assign o_rsp.ambient_temp  = r_sample_valid ? $signed(ram_rdata[31:16]) : '0;
    assign o_rsp.sequence_res  = r_sequence;
    assign o_rsp.available     = r_available;
    assign o_rsp.error_count   = r_error_count;
    assign o_rsp.overrun_count = r_overrun_count;

    // ---------------- Assertions ----------------
    a_pop_has_no_bus_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sample_valid) |-> (r_bus_op == BUS_NONE))
        else $error("popped sample reported with a bus operation");

    a_result_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_error_count)))
        else $error("result dropped or changed while stalled");

    a_abort_counts_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_req.action && r_phase == PH_CHECK && i_req.abort_seen)
        |=> (r_fault_count == $past(r_fault_count) + CNT_W'(1)) && (r_phase == PH_DISABLE))
        else $error("bus abort not counted as a fault");

    a_drop_only_on_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.action) |=> $stable(r_dropped_count) && $stable(r_write_index))
        else $error("pop changed write side of the ring");

    a_pop_on_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.action && avail_now == '0) |=> !r_sample_valid)
        else $error("sample popped from an empty ring");

endmodule
